// File: design/pbrd_pkg.sv
`timescale 1ns / 1ps

package pbrd_pkg;

  // Depth of the queue between the front and the back part.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Header codes of the PackBits format.
  localparam logic [7:0] HDR_NOOP    = 8'h80;
  localparam logic [8:0] REPEAT_BASE = 9'd257;

  // Decoder phase, one-hot.
  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_LITERAL = 3'b010,
    PH_REPEAT  = 3'b100
  } phase_t;

  // One classified compressed byte, as the front hands it to the back.
  typedef struct packed {
    logic [7:0] code_byte;
    logic       row_end;
    logic       is_literal;  // header 0..127
    logic       is_noop;     // header -128
    logic [7:0] hdr_count;   // run length if this byte is a header
  } entry_t;

endpackage

// File: design/packbits_row_decoder.sv
`timescale 1ns / 1ps
// PackBits row decoder: one compressed byte per item, run descriptors out.
// Path: the accepting edge writes the byte into the queue; once the back pops it,
// its result is registered in the output register and offered there.
// Throughput: one byte per cycle while the queue is not full and out_ready does not hold the output.
// Reset: synchronous rst clears row state, the queue, out_valid and row_width.

module packbits_row_decoder import pbrd_pkg::*; #(
  parameter int POSITION_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [19:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  code_byte,
  input  logic        row_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_value,
  output logic [7:0]  repeat_count,
  output logic        row_done,
  output logic        row_status
);

  logic [19:0]              row_width;
  logic [POSITION_BITS-1:0] width;
  logic                     q_valid;
  logic                     q_pop;
  entry_t                   q_head;

  // The row width register. Only the low POSITION_BITS bits take part in
  // position checks; narrower configurations simply ignore the upper bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= '0;
    end else if (cfg_we) begin
      row_width <= cfg_wdata;
    end
  end

  assign width = POSITION_BITS'(row_width);

  // The front classifies each byte as a header and buffers it, so up to QDEPTH input
  // bytes can still be taken while a finished run waits at the output.
  pbrd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .code_byte (code_byte),
    .row_end   (row_end),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_head    (q_head)
  );

  // The back tracks phase and position, flags corrupt rows and emits runs.
  pbrd_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .width        (width),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_head       (q_head),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_value    (out_value),
    .repeat_count (repeat_count),
    .row_done     (row_done),
    .row_status   (row_status)
  );

endmodule

// File: design/pbrd_front.sv
`timescale 1ns / 1ps

module pbrd_front import pbrd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] code_byte,
  input  logic       row_end,
  output logic       q_valid,
  input  logic       q_pop,
  output entry_t     q_head
);

  entry_t              store [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  entry_t              classified;
  logic                push;
  logic                pop;

  // Header classification does not depend on decoder state, so it is done here.
  always_comb begin
    classified.code_byte  = code_byte;
    classified.row_end    = row_end;
    classified.is_literal = ~code_byte[7];
    classified.is_noop    = (code_byte == HDR_NOOP);
    if (!code_byte[7]) begin
      classified.hdr_count = code_byte + 8'd1;
    end else begin
      classified.hdr_count = 8'(REPEAT_BASE - {1'b0, code_byte});
    end
  end

  assign in_ready = (count != QCNT_W'(QDEPTH));
  assign push     = in_valid & in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop & q_valid;
  assign q_head   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= classified;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: design/pbrd_back.sv
`timescale 1ns / 1ps

module pbrd_back import pbrd_pkg::*; #(
  parameter int POSITION_BITS = 20
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [POSITION_BITS-1:0] width,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  entry_t                   q_head,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_value,
  output logic [7:0]               repeat_count,
  output logic                     row_done,
  output logic                     row_status
);

  phase_t                   phase, phase_next;
  logic [7:0]               literal_left, literal_left_next;
  logic [7:0]               repeat_len, repeat_len_next;
  logic [POSITION_BITS-1:0] out_position, out_position_next;
  logic                     corrupt_flag, corrupt_flag_next;

  logic                     have_run;
  logic [7:0]               run_cnt;
  logic [POSITION_BITS:0]   run_end;
  logic                     overfill;
  logic                     emit;
  logic                     bad;

  assign q_pop    = q_valid & (~out_valid | out_ready);
  assign run_end  = {1'b0, out_position} + (POSITION_BITS + 1)'(q_head.hdr_count);
  assign overfill = (run_end > {1'b0, width});

  always_comb begin
    phase_next        = phase;
    literal_left_next = literal_left;
    repeat_len_next   = repeat_len;
    out_position_next = out_position;
    corrupt_flag_next = corrupt_flag;
    have_run          = 1'b0;
    run_cnt           = 8'd0;
    if (!corrupt_flag) begin
      unique case (phase)
        PH_HEADER: begin
          if (out_position >= width) begin
            corrupt_flag_next = 1'b1;
          end else if (!q_head.is_noop) begin
            if (overfill) begin
              corrupt_flag_next = 1'b1;
            end else if (q_head.is_literal) begin
              literal_left_next = q_head.hdr_count;
              phase_next        = PH_LITERAL;
            end else begin
              repeat_len_next = q_head.hdr_count;
              phase_next      = PH_REPEAT;
            end
          end
        end
        PH_LITERAL: begin
          have_run          = 1'b1;
          run_cnt           = 8'd1;
          out_position_next = out_position + 1'b1;
          literal_left_next = literal_left - 8'd1;
          if (literal_left == 8'd1) begin
            phase_next = PH_HEADER;
          end
        end
        PH_REPEAT: begin
          have_run          = 1'b1;
          run_cnt           = repeat_len;
          out_position_next = out_position + POSITION_BITS'(repeat_len);
          repeat_len_next   = 8'd0;
          phase_next        = PH_HEADER;
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
    bad  = corrupt_flag_next | (phase_next != PH_HEADER) | (out_position_next != width);
    emit = have_run | q_head.row_end;
  end

  // Decoder state. The end of a row returns everything to its reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      literal_left <= '0;
      repeat_len   <= '0;
      out_position <= '0;
      corrupt_flag <= 1'b0;
    end else if (q_pop) begin
      if (q_head.row_end) begin
        phase        <= PH_HEADER;
        literal_left <= '0;
        repeat_len   <= '0;
        out_position <= '0;
        corrupt_flag <= 1'b0;
      end else begin
        phase        <= phase_next;
        literal_left <= literal_left_next;
        repeat_len   <= repeat_len_next;
        out_position <= out_position_next;
        corrupt_flag <= corrupt_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_value    <= have_run ? q_head.code_byte : 8'd0;
      repeat_count <= run_cnt;
      row_done     <= q_head.row_end;
      row_status   <= q_head.row_end & bad;
    end
  end

endmodule
